// File: rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the UTF-8 encoder used by the transcoder top.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam logic [5:0]  HIGH_TAG    = 6'b110110;  // 0xD800-0xDBFF
  localparam logic [5:0]  LOW_TAG     = 6'b110111;  // 0xDC00-0xDFFF
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] LIMIT_ONE   = 21'h80;
  localparam logic [20:0] LIMIT_TWO   = 21'h800;
  localparam logic [20:0] LIMIT_THREE = 21'h10000;
  localparam logic [7:0]  LEAD_TWO    = 8'hC0;
  localparam logic [7:0]  LEAD_THREE  = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;

  // Up to four bytes of one code point, first byte in entry 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_seq_t;

  function automatic utf8_seq_t utf8_encode(input logic [20:0] c);
    utf8_seq_t s;
    s = '0;
    if (c < LIMIT_ONE) begin
      s.bytes[0] = c[7:0];
      s.len      = 3'd1;
    end else if (c < LIMIT_TWO) begin
      s.bytes[0] = LEAD_TWO | {3'b000, c[10:6]};
      s.bytes[1] = CONT_MARK | {2'b00, c[5:0]};
      s.len      = 3'd2;
    end else if (c < LIMIT_THREE) begin
      s.bytes[0] = LEAD_THREE | {4'b0000, c[15:12]};
      s.bytes[1] = CONT_MARK | {2'b00, c[11:6]};
      s.bytes[2] = CONT_MARK | {2'b00, c[5:0]};
      s.len      = 3'd3;
    end else begin
      s.bytes[0] = LEAD_FOUR | {5'b00000, c[20:18]};
      s.bytes[1] = CONT_MARK | {2'b00, c[17:12]};
      s.bytes[2] = CONT_MARK | {2'b00, c[11:6]};
      s.bytes[3] = CONT_MARK | {2'b00, c[5:0]};
      s.len      = 3'd4;
    end
    return s;
  endfunction

endpackage

// File: rtl/u16u8_if.sv
// ----------------------------------------------------------------------------
// u16u8 stream interfaces
// Valid/ready channels for UTF-16 code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u16u8_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        is_terminator;
  logic [31:0] byte_count;

  modport source (output valid, output out_byte, output last_of_run,
                  output is_terminator, output byte_count, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input is_terminator, input byte_count, output ready);
endinterface

// File: rtl/utf16_to_utf8_transcoder_top.sv
// The first byte of a unit is registered in the byte buffer and then in the
// output register. Bytes leave at one per cycle while byte_ch.ready allows; a
// unit (terminator included) holds the buffer until its last byte moves out,
// and a held high surrogate with no output does not load the buffer.
// Reset (rst, synchronous) drops any held surrogate, clears the byte count and
// empties the buffer and output register.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// Converts a stream of UTF-16 code units to UTF-8 bytes with a terminator.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top
  import u16u8_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  u16u8_unit_if.sink    unit_ch,
  u16u8_byte_if.source  byte_ch
);

  // Surrogate and count state.
  logic [15:0] held_unit;
  logic        held_valid;
  logic [31:0] bytes_so_far;

  // Byte buffer holding the results of one unit.
  logic        buf_valid;
  utf8_seq_t   buf_a;
  utf8_seq_t   buf_b;
  logic        buf_term;
  logic [31:0] buf_count;
  logic [2:0]  buf_idx;
  logic [2:0]  buf_total;

  // Output register.
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_term;
  logic [31:0] out_count;

  // Decode of the incoming unit.
  logic        accept;
  logic        load;
  logic        is_high;
  logic        is_low;
  logic        consumed;
  logic        keep_high;
  logic [20:0] pair_code;
  utf8_seq_t   seg_a;
  utf8_seq_t   seg_b;
  logic [2:0]  data_len;
  logic [2:0]  run_len;
  logic [32:0] count_sum;
  logic [31:0] count_sat;

  // Buffer drain.
  logic        move;
  logic        buf_last;
  logic [2:0]  b_off;
  logic [7:0]  sel_byte;

  assign is_high   = (unit_ch.code_unit[15:10] == HIGH_TAG);
  assign is_low    = (unit_ch.code_unit[15:10] == LOW_TAG);
  assign consumed  = held_valid && is_low;
  assign keep_high = !consumed && is_high && !unit_ch.end_of_string;
  assign pair_code = SUPP_BASE + {1'b0, held_unit[9:0], unit_ch.code_unit[9:0]};

  always_comb begin
    seg_a = '0;
    seg_b = '0;
    if (consumed) begin
      seg_a = utf8_encode(pair_code);
    end else if (held_valid) begin
      // An unpaired high surrogate goes out in its own three-byte form.
      seg_a = utf8_encode({5'b00000, held_unit});
    end
    if (!consumed && !keep_high) begin
      seg_b = utf8_encode({5'b00000, unit_ch.code_unit});
    end
  end

  assign data_len  = seg_a.len + seg_b.len;
  assign run_len   = data_len + {2'b00, unit_ch.end_of_string};
  assign count_sum = {1'b0, bytes_so_far} + {30'd0, data_len};
  assign count_sat = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];

  assign move     = buf_valid && (!out_valid || byte_ch.ready);
  assign buf_last = (buf_idx == (buf_total - 3'd1));
  assign b_off    = buf_idx - buf_a.len;

  always_comb begin
    if (buf_idx < buf_a.len) begin
      sel_byte = buf_a.bytes[buf_idx[1:0]];
    end else if (b_off < buf_b.len) begin
      sel_byte = buf_b.bytes[b_off[1:0]];
    end else begin
      sel_byte = 8'h00;
    end
  end

  // A new unit is taken while the last byte of the previous one moves out.
  assign unit_ch.ready = !buf_valid || (move && buf_last);
  assign accept        = unit_ch.valid && unit_ch.ready;
  assign load          = accept && (run_len != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_unit    <= '0;
      held_valid   <= 1'b0;
      bytes_so_far <= '0;
      buf_valid    <= 1'b0;
      buf_idx      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        held_valid   <= keep_high;
        held_unit    <= keep_high ? unit_ch.code_unit : 16'h0000;
        bytes_so_far <= unit_ch.end_of_string ? 32'd0 : count_sat;
      end

      if (move) begin
        out_valid <= 1'b1;
        out_byte  <= sel_byte;
        out_last  <= buf_last;
        out_term  <= buf_last && buf_term;
        out_count <= (buf_last && buf_term) ? buf_count : 32'd0;
        if (!buf_last) begin
          buf_idx <= buf_idx + 3'd1;
        end else if (!load) begin
          buf_valid <= 1'b0;
        end
      end else if (byte_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (load) begin
        buf_valid <= 1'b1;
        buf_idx   <= '0;
        buf_a     <= seg_a;
        buf_b     <= seg_b;
        buf_term  <= unit_ch.end_of_string;
        buf_count <= count_sat;
        buf_total <= run_len;
      end
    end
  end

  assign byte_ch.valid         = out_valid;
  assign byte_ch.out_byte      = out_byte;
  assign byte_ch.last_of_run   = out_last;
  assign byte_ch.is_terminator = out_term;
  assign byte_ch.byte_count    = out_count;

  // The terminator always closes the run of its unit.
  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_term |-> out_last)
    else $error("terminator beat without last_of_run");

  // The count is only carried on the terminator beat.
  a_count_on_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_term |-> (out_count == 32'd0))
    else $error("nonzero byte_count on a data beat");

  // Only a high surrogate is ever held.
  a_held_is_high: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (held_unit[15:10] == HIGH_TAG))
    else $error("held unit is not a high surrogate");

  // The drain index stays inside the loaded run.
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (buf_idx < buf_total))
    else $error("buffer index beyond run length");

endmodule
